// ===== hdl/bgdr_pkg.sv =====
`timescale 1ns / 1ps

package bgdr_pkg;

	// Input action codes
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_TRAIN   = 2'd1;
	localparam logic [1:0] ACT_PREDICT = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_CAP   = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_RATE    = 3'd0;
	localparam logic [2:0] REG_LIMIT   = 3'd1;
	localparam logic [2:0] REG_BIAS    = 3'd2;
	localparam logic [2:0] REG_WA      = 3'd3;
	localparam logic [2:0] REG_WB      = 3'd4;
	localparam logic [2:0] REG_EPOCHS  = 3'd5;

	// Configuration reset values
	localparam logic [47:0] RST_RATE   = 48'd281475;
	localparam logic [47:0] RST_LIMIT  = 48'd6554;
	localparam logic [63:0] RST_BIAS   = 64'd54975581389;
	localparam logic [63:0] RST_WA     = 64'd1099511628;
	localparam logic [63:0] RST_WB     = 64'd21990232556;
	localparam logic [19:0] RST_EPOCHS = 20'd65535;

	// Dividend width of the cost divide: cost_sum >> 17
	localparam int DVD_W = 47;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_EPOCH, S_RD, S_MA, S_MB, S_H, S_SQ,
		S_GA, S_GB, S_DIV, S_CHK, S_U0, S_U1, S_U2, S_OUT
	} state_t;

	// Request to the shared multiplier
	typedef struct packed {
		logic go;
		logic sh24;
	} mul_req_t;

	// Multiplier status back to the sequencer
	typedef struct packed {
		logic              done;
		logic signed [63:0] sat;
		logic [63:0]       lo;
	} mul_rsp_t;

	// Signed 64-bit add with saturation
	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63])
			return {1'b0, {63{1'b1}}};
		else if (a[63] && b[63] && !s[63])
			return {1'b1, {63{1'b0}}};
		else
			return s;
	endfunction

endpackage

// ===== hdl/bgdr_mul.sv =====
`timescale 1ns / 1ps

// Shared 64x64 multiplier, one 32x32 partial product per cycle.
// Result is the signed product, optionally shifted right 24 toward zero,
// saturated to 64 bits; lo is the low 64 bits of the unsigned magnitude.
module bgdr_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  bgdr_pkg::mul_req_t req,
	input  logic signed [63:0] a,
	input  logic [63:0]        b,
	output bgdr_pkg::mul_rsp_t rsp
);

	logic [63:0]  m_q;
	logic [63:0]  b_q;
	logic         neg_q;
	logic         sh_q;
	logic [127:0] acc_q;
	logic [1:0]   k_q;
	logic         busy_q;
	logic         fin_q;
	logic         done_q;
	logic signed [63:0] sat_q;
	logic [63:0]  lo_q;

	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] shifted;
	logic signed [63:0] sat_d;

	// Partial product of the current digit pair
	always_comb begin
		pp = 64'(m_q[k_q[1]*32 +: 32]) * 64'(b_q[k_q[0]*32 +: 32]);
		case ({1'b0, k_q[1]} + {1'b0, k_q[0]})
			2'd0: pp_sh = {64'd0, pp};
			2'd1: pp_sh = {32'd0, pp, 32'd0};
			default: pp_sh = {pp, 64'd0};
		endcase
	end

	// Shift and saturate the finished magnitude
	always_comb begin
		shifted = sh_q ? (acc_q >> 24) : acc_q;
		if (!neg_q)
			sat_d = (shifted[127:63] != '0) ? {1'b0, {63{1'b1}}} : shifted[63:0];
		else if (shifted[127:63] != '0)
			sat_d = {1'b1, {63{1'b0}}};
		else
			sat_d = -$signed(shifted[63:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= !req.go && busy_q && fin_q;
			if (req.go) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				k_q    <= '0;
			end else if (busy_q && !fin_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd3)
					fin_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
			end
		end
	end

	// Operand capture and accumulation
	always_ff @(posedge clk) begin
		if (req.go) begin
			neg_q <= a[63];
			m_q   <= a[63] ? 64'(-a) : 64'(a);
			b_q   <= b;
			sh_q  <= req.sh24;
			acc_q <= '0;
		end else if (busy_q && !fin_q) begin
			acc_q <= acc_q + pp_sh;
		end else if (busy_q) begin
			sat_q <= sat_d;
			lo_q  <= acc_q[63:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign rsp.lo   = lo_q;

endmodule

// ===== hdl/bgdr_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module bgdr_div #(
	parameter int CW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [bgdr_pkg::DVD_W-1:0] dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic [bgdr_pkg::DVD_W-1:0] quot
);

	localparam int NW = $clog2(bgdr_pkg::DVD_W + 1);

	logic [bgdr_pkg::DVD_W-1:0] dq_q;
	logic [CW:0]                rem_q;
	logic [CW-1:0]              dsr_q;
	logic [NW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [CW:0] trial;
	logic        fits;

	always_comb begin
		trial = {rem_q[CW-1:0], dq_q[bgdr_pkg::DVD_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !go && busy_q && (cnt_q == NW'(bgdr_pkg::DVD_W - 1));
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == NW'(bgdr_pkg::DVD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			dq_q  <= {dq_q[bgdr_pkg::DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

// ===== hdl/batch_gradient_descent_regression.sv =====
`timescale 1ns / 1ps

// Channel  Signals                                   Direction
// input    in_valid, in_stall, action..target        in (stall out)
// output   out_valid, out_stall, status..sample_total out (stall in)
// config   cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// Predict makes two passes through the shared multiplier. Each train epoch
// makes five passes through the shared 64x64 multiplier per stored sample,
// then a cost divide and, unless the fit ends there, three weight-update
// multiplies.
// in_stall is high from acceptance until the result is in the output register.
// Reset clears control state; config registers return to their defaults.
module batch_gradient_descent_regression #(
	parameter int MAX_SAMPLES = 16,
	parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [15:0]        feature_a,
	input  logic [15:0]        feature_b,
	input  logic signed [31:0] target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [63:0] weight_bias,
	output logic signed [63:0] weight_a,
	output logic signed [63:0] weight_b,
	output logic [47:0]        cost,
	output logic [19:0]        epochs_run,
	output logic signed [31:0] prediction,
	output logic [CW-1:0]      sample_total,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	// Configuration registers
	logic [47:0]        rate_q;
	logic [47:0]        limit_q;
	logic signed [63:0] ibias_q, iwa_q, iwb_q;
	logic [19:0]        maxep_q;

	// Sample store
	logic [15:0]        mem_a [MAX_SAMPLES];
	logic [15:0]        mem_b [MAX_SAMPLES];
	logic signed [31:0] mem_y [MAX_SAMPLES];
	logic [15:0]        rd_a_q, rd_b_q;
	logic signed [31:0] rd_y_q;

	// Control and datapath state
	bgdr_pkg::state_t   state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic               pred_q;
	logic               issued_q;
	logic [15:0]        in_a_q, in_b_q;
	logic signed [63:0] w_q [3];
	logic signed [63:0] g_q [3];
	logic [63:0]        csum_q;
	logic [47:0]        cost_q;
	logic [19:0]        epoch_q;
	logic signed [63:0] hacc_q;
	logic signed [32:0] r_q;
	logic signed [31:0] hpred_q;
	logic [1:0]         st_q;

	// Output register
	logic               ovalid_q;
	logic [1:0]         o_status_q;
	logic signed [63:0] o_w0_q, o_w1_q, o_w2_q;
	logic [47:0]        o_cost_q;
	logic [19:0]        o_ep_q;
	logic signed [31:0] o_pred_q;
	logic [CW-1:0]      o_cnt_q;

	bgdr_pkg::mul_req_t mreq;
	bgdr_pkg::mul_rsp_t mrsp;
	logic signed [63:0] m_a;
	logic [63:0]        m_b;
	logic               div_go, div_done;
	logic [bgdr_pkg::DVD_W-1:0] quot;

	logic               in_acc;
	logic               mul_state;
	logic [15:0]        fa_sel, fb_sel;
	logic signed [31:0] y_sel;
	logic signed [39:0] hq;
	logic signed [31:0] h;
	logic [31:0]        mag;
	logic [64:0]        csum_add;
	logic [19:0]        cap;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != bgdr_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= bgdr_pkg::RST_RATE;
			limit_q <= bgdr_pkg::RST_LIMIT;
			ibias_q <= bgdr_pkg::RST_BIAS;
			iwa_q   <= bgdr_pkg::RST_WA;
			iwb_q   <= bgdr_pkg::RST_WB;
			maxep_q <= bgdr_pkg::RST_EPOCHS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgdr_pkg::REG_RATE:   rate_q  <= cfg_data[47:0];
				bgdr_pkg::REG_LIMIT:  limit_q <= cfg_data[47:0];
				bgdr_pkg::REG_BIAS:   ibias_q <= cfg_data;
				bgdr_pkg::REG_WA:     iwa_q   <= cfg_data;
				bgdr_pkg::REG_WB:     iwb_q   <= cfg_data;
				bgdr_pkg::REG_EPOCHS: maxep_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// Sample memory: write on load, registered read at the sample index
	always_ff @(posedge clk) begin
		if (in_acc && action == bgdr_pkg::ACT_LOAD && count_q < CW'(MAX_SAMPLES)) begin
			mem_a[count_q[IW-1:0]] <= feature_a;
			mem_b[count_q[IW-1:0]] <= feature_b;
			mem_y[count_q[IW-1:0]] <= target;
		end
		rd_a_q <= mem_a[idx_q[IW-1:0]];
		rd_b_q <= mem_b[idx_q[IW-1:0]];
		rd_y_q <= mem_y[idx_q[IW-1:0]];
	end

	// Datapath selects
	always_comb begin
		fa_sel = pred_q ? in_a_q : rd_a_q;
		fb_sel = pred_q ? in_b_q : rd_b_q;
		y_sel  = rd_y_q;
		hq     = 40'(hacc_q >>> 24);
		if (hq > 40'sd2147483647)
			h = 32'sh7fffffff;
		else if (hq < -40'sd2147483648)
			h = 32'sh80000000;
		else
			h = hq[31:0];
		mag      = r_q[32] ? 32'(-r_q) : r_q[31:0];
		csum_add = {1'b0, csum_q} + {1'b0, mrsp.lo};
		cap      = (maxep_q == '0) ? 20'd1 : maxep_q;
	end

	// Multiplier operands by state
	always_comb begin
		m_a       = '0;
		m_b       = '0;
		mreq.sh24 = 1'b0;
		mul_state = 1'b1;
		unique case (state_q)
			bgdr_pkg::S_MA: begin m_a = w_q[1]; m_b = 64'(fa_sel); end
			bgdr_pkg::S_MB: begin m_a = w_q[2]; m_b = 64'(fb_sel); end
			bgdr_pkg::S_SQ: begin m_a = 64'(mag); m_b = 64'(mag); end
			bgdr_pkg::S_GA: begin m_a = 64'(r_q); m_b = 64'(rd_a_q); end
			bgdr_pkg::S_GB: begin m_a = 64'(r_q); m_b = 64'(rd_b_q); end
			bgdr_pkg::S_U0: begin m_a = g_q[0]; m_b = 64'(rate_q); mreq.sh24 = 1'b1; end
			bgdr_pkg::S_U1: begin m_a = g_q[1]; m_b = 64'(rate_q); mreq.sh24 = 1'b1; end
			bgdr_pkg::S_U2: begin m_a = g_q[2]; m_b = 64'(rate_q); mreq.sh24 = 1'b1; end
			default: mul_state = 1'b0;
		endcase
		mreq.go = mul_state && !issued_q;
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		div_go  = (state_q == bgdr_pkg::S_DIV) && !issued_q;
		unique case (state_q)
			bgdr_pkg::S_IDLE: begin
				if (in_acc) begin
					case (action)
						bgdr_pkg::ACT_PREDICT: state_d = bgdr_pkg::S_MA;
						bgdr_pkg::ACT_TRAIN:
							state_d = (count_q == '0) ? bgdr_pkg::S_OUT : bgdr_pkg::S_INIT;
						default: state_d = bgdr_pkg::S_OUT;
					endcase
				end
			end
			bgdr_pkg::S_INIT:  state_d = bgdr_pkg::S_EPOCH;
			bgdr_pkg::S_EPOCH: state_d = bgdr_pkg::S_RD;
			bgdr_pkg::S_RD:    state_d = bgdr_pkg::S_MA;
			bgdr_pkg::S_MA:    if (mrsp.done) state_d = bgdr_pkg::S_MB;
			bgdr_pkg::S_MB:    if (mrsp.done) state_d = bgdr_pkg::S_H;
			bgdr_pkg::S_H:     state_d = pred_q ? bgdr_pkg::S_OUT : bgdr_pkg::S_SQ;
			bgdr_pkg::S_SQ:    if (mrsp.done) state_d = bgdr_pkg::S_GA;
			bgdr_pkg::S_GA:    if (mrsp.done) state_d = bgdr_pkg::S_GB;
			bgdr_pkg::S_GB: begin
				if (mrsp.done)
					state_d = (idx_q + 1'b1 == count_q) ? bgdr_pkg::S_DIV : bgdr_pkg::S_RD;
			end
			bgdr_pkg::S_DIV:   if (div_done) state_d = bgdr_pkg::S_CHK;
			bgdr_pkg::S_CHK: begin
				if (cost_q <= limit_q || epoch_q >= cap)
					state_d = bgdr_pkg::S_OUT;
				else
					state_d = bgdr_pkg::S_U0;
			end
			bgdr_pkg::S_U0:    if (mrsp.done) state_d = bgdr_pkg::S_U1;
			bgdr_pkg::S_U1:    if (mrsp.done) state_d = bgdr_pkg::S_U2;
			bgdr_pkg::S_U2:    if (mrsp.done) state_d = bgdr_pkg::S_EPOCH;
			bgdr_pkg::S_OUT:   if (!ovalid_q || !out_stall) state_d = bgdr_pkg::S_IDLE;
			default:           state_d = bgdr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bgdr_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			issued_q <= 1'b0;
			epoch_q  <= '0;
			cost_q   <= '0;
			w_q[0]   <= bgdr_pkg::RST_BIAS;
			w_q[1]   <= bgdr_pkg::RST_WA;
			w_q[2]   <= bgdr_pkg::RST_WB;
			ovalid_q <= 1'b0;
		end else begin
			if (mreq.go || div_go)
				issued_q <= 1'b1;
			else if (mrsp.done || div_done)
				issued_q <= 1'b0;

			if (in_acc && action == bgdr_pkg::ACT_LOAD && count_q < CW'(MAX_SAMPLES))
				count_q <= count_q + 1'b1;
			else if (in_acc && action == bgdr_pkg::ACT_CLEAR)
				count_q <= '0;

			if (state_q == bgdr_pkg::S_INIT) begin
				w_q[0]  <= ibias_q;
				w_q[1]  <= iwa_q;
				w_q[2]  <= iwb_q;
				epoch_q <= '0;
			end
			if (state_q == bgdr_pkg::S_EPOCH)
				epoch_q <= epoch_q + 1'b1;
			if (div_done)
				cost_q <= 48'(quot);
			if (mrsp.done && state_q == bgdr_pkg::S_U0)
				w_q[0] <= bgdr_pkg::add_sat(w_q[0], mrsp.sat);
			if (mrsp.done && state_q == bgdr_pkg::S_U1)
				w_q[1] <= bgdr_pkg::add_sat(w_q[1], mrsp.sat);
			if (mrsp.done && state_q == bgdr_pkg::S_U2)
				w_q[2] <= bgdr_pkg::add_sat(w_q[2], mrsp.sat);

			// Result register fills from S_OUT, drains on its transfer
			if (state_q == bgdr_pkg::S_OUT && (!ovalid_q || !out_stall))
				ovalid_q <= 1'b1;
			else if (out_valid && !out_stall)
				ovalid_q <= 1'b0;
		end
	end

	// Input capture, epoch datapath and output registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_a_q <= feature_a;
			in_b_q <= feature_b;
			pred_q <= (action == bgdr_pkg::ACT_PREDICT);
			if (action == bgdr_pkg::ACT_LOAD && count_q >= CW'(MAX_SAMPLES))
				st_q <= bgdr_pkg::ST_FULL;
			else if (action == bgdr_pkg::ACT_TRAIN && count_q == '0)
				st_q <= bgdr_pkg::ST_EMPTY;
			else
				st_q <= bgdr_pkg::ST_OK;
		end
		if (state_q == bgdr_pkg::S_EPOCH) begin
			idx_q  <= '0;
			csum_q <= '0;
			g_q[0] <= '0;
			g_q[1] <= '0;
			g_q[2] <= '0;
		end
		if (mrsp.done && state_q == bgdr_pkg::S_MA)
			hacc_q <= bgdr_pkg::add_sat(w_q[0], mrsp.sat);
		if (mrsp.done && state_q == bgdr_pkg::S_MB)
			hacc_q <= bgdr_pkg::add_sat(hacc_q, mrsp.sat);
		if (state_q == bgdr_pkg::S_H) begin
			hpred_q <= h;
			r_q     <= 33'(y_sel) - 33'(h);
		end
		if (state_q == bgdr_pkg::S_SQ && mrsp.done)
			csum_q <= csum_add[64] ? '1 : csum_add[63:0];
		if (state_q == bgdr_pkg::S_SQ && mrsp.done)
			g_q[0] <= bgdr_pkg::add_sat(g_q[0], 64'(r_q));
		if (state_q == bgdr_pkg::S_GA && mrsp.done)
			g_q[1] <= bgdr_pkg::add_sat(g_q[1], mrsp.sat);
		if (state_q == bgdr_pkg::S_GB && mrsp.done) begin
			g_q[2] <= bgdr_pkg::add_sat(g_q[2], mrsp.sat);
			idx_q  <= idx_q + 1'b1;
		end
		if (state_q == bgdr_pkg::S_CHK)
			st_q <= (cost_q <= limit_q) ? bgdr_pkg::ST_OK : bgdr_pkg::ST_CAP;
		if (state_q == bgdr_pkg::S_OUT && (!ovalid_q || !out_stall)) begin
			o_status_q <= st_q;
			o_w0_q     <= w_q[0];
			o_w1_q     <= w_q[1];
			o_w2_q     <= w_q[2];
			o_cost_q   <= cost_q;
			o_ep_q     <= epoch_q;
			o_pred_q   <= pred_q ? hpred_q : '0;
			o_cnt_q    <= count_q;
		end
	end

	bgdr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.a      (m_a),
		.b      (m_b),
		.rsp    (mrsp)
	);

	bgdr_div #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (csum_q[63:17]),
		.divisor  (count_q),
		.done     (div_done),
		.quot     (quot)
	);

	assign out_valid    = ovalid_q;
	assign status       = o_status_q;
	assign weight_bias  = o_w0_q;
	assign weight_a     = o_w1_q;
	assign weight_b     = o_w2_q;
	assign cost         = o_cost_q;
	assign epochs_run   = o_ep_q;
	assign prediction   = o_pred_q;
	assign sample_total = o_cnt_q;

endmodule

// ===== hdl/bgdr_chk.sv =====
`timescale 1ns / 1ps

// Port-level checks on the regression block
module bgdr_chk #(
	parameter int MAX_SAMPLES = 16,
	parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [19:0]        epochs_run,
	input logic [CW-1:0]      sample_total
);

	// A result stays offered until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// The block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken without going busy");

	// Store count never exceeds its depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_total <= CW'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	// Hitting the epoch cap means at least one epoch ran
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bgdr_pkg::ST_CAP |-> epochs_run != '0)
		else $error("epoch cap flagged with no epochs");

endmodule

bind batch_gradient_descent_regression bgdr_chk #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW)) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.action       (action),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.epochs_run   (epochs_run),
	.sample_total (sample_total)
);

// ===== test/batch_gradient_descent_regression_tb.sv =====
`timescale 1ns / 1ps

module batch_gradient_descent_regression_tb;

	localparam int N_ITEMS    = 1550;
	localparam int IDLE_LIMIT = 40000;
	localparam int STORE_SIZE = 16;
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct {
		logic [1:0]         act;
		logic [15:0]        fa;
		logic [15:0]        fb;
		logic signed [31:0] tgt;
	} req_t;

	typedef struct {
		logic [1:0]         status;
		logic signed [63:0] w0, w1, w2;
		logic [47:0]        cost;
		logic [19:0]        epochs;
		logic signed [31:0] pred;
		logic [4:0]         total;
	} fit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = bgdr_pkg::ACT_LOAD;
	logic [15:0]        feature_a = '0;
	logic [15:0]        feature_b = '0;
	logic signed [31:0] target = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [63:0] weight_bias, weight_a, weight_b;
	logic [47:0]        cost;
	logic [19:0]        epochs_run;
	logic signed [31:0] prediction;
	logic [4:0]         sample_total;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = bgdr_pkg::REG_RATE;
	logic [63:0]        cfg_data = '0;

	batch_gradient_descent_regression i_dut (.*);

	always #10 clk = ~clk;

	// Mirror of the block: config, sample store and model
	logic [47:0]        m_rate = bgdr_pkg::RST_RATE;
	logic [47:0]        m_limit = bgdr_pkg::RST_LIMIT;
	logic signed [63:0] m_init [3] = '{bgdr_pkg::RST_BIAS, bgdr_pkg::RST_WA,
		bgdr_pkg::RST_WB};
	logic [19:0]        m_cap = bgdr_pkg::RST_EPOCHS;
	logic [15:0]        s_fa [STORE_SIZE];
	logic [15:0]        s_fb [STORE_SIZE];
	logic signed [31:0] s_tgt [STORE_SIZE];
	int unsigned        s_cnt = 0;
	logic signed [63:0] m_w [3] = '{bgdr_pkg::RST_BIAS, bgdr_pkg::RST_WA,
		bgdr_pkg::RST_WB};
	logic [63:0]        m_cost = '0;
	logic [19:0]        m_epochs = '0;

	req_t  pending_q [$];
	fit_t  fit_q [$];
	int    n_sent = 0, n_checked = 0, n_fail = 0;
	int    n_conv = 0, n_cap = 0, n_full = 0, n_empty = 0, n_pred = 0, n_epochs = 0;
	bit    in_took = 0, out_took = 0, quiet = 0, pressure_req = 0;
	int    in_gap = 0, out_gap = 0, hold_left = 0, idle_cycles = 0;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (!a[63] && !b[63] && s[63]) return S64_MAX;
		if (a[63] && b[63] && !s[63]) return S64_MIN;
		return s;
	endfunction

	// Signed by unsigned product, shifted toward zero and saturated
	function automatic logic signed [63:0] sat_mul(logic signed [63:0] a, logic [63:0] b,
		int sh);
		logic [63:0]  mag;
		logic [127:0] p;
		mag = a[63] ? -a : a;
		p = ({64'b0, mag} * {64'b0, b}) >> sh;
		if (!a[63]) return (p > 128'(S64_MAX)) ? S64_MAX : p[63:0];
		if (p > {64'b0, 1'b1, 63'b0}) return S64_MIN;
		return -p[63:0];
	endfunction

	function automatic logic signed [31:0] model_out(logic [15:0] a, logic [15:0] b);
		logic signed [63:0] s;
		s = sat_add(m_w[0], sat_mul(m_w[1], {48'b0, a}, 0));
		s = sat_add(s, sat_mul(m_w[2], {48'b0, b}, 0));
		s = s >>> 24;
		if (s > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (s < -64'sh80000000) return 32'sh80000000;
		return s[31:0];
	endfunction

	task automatic fit_model(output logic [1:0] st);
		int unsigned        cap;
		logic [63:0]        csum, sq, mag, nsum;
		logic signed [63:0] g [3];
		logic signed [63:0] r;
		cap = (m_cap == 0) ? 1 : m_cap;
		if (s_cnt == 0) begin
			st = bgdr_pkg::ST_EMPTY;
			return;
		end
		m_w = m_init;
		m_epochs = 0;
		forever begin
			m_epochs++;
			csum = 0;
			g = '{0, 0, 0};
			for (int i = 0; i < s_cnt; i++) begin
				r = 64'(s_tgt[i]) - 64'(model_out(s_fa[i], s_fb[i]));
				mag = r[63] ? -r : r;
				sq = mag * mag;
				nsum = csum + sq;
				csum = (nsum < csum) ? '1 : nsum;
				g[0] = sat_add(g[0], r);
				g[1] = sat_add(g[1], sat_mul(r, {48'b0, s_fa[i]}, 0));
				g[2] = sat_add(g[2], sat_mul(r, {48'b0, s_fb[i]}, 0));
			end
			m_cost = (csum >> 17) / s_cnt;
			if (m_cost > 64'hFFFF_FFFF_FFFF) m_cost = 64'hFFFF_FFFF_FFFF;
			if (m_cost <= m_limit) begin
				st = bgdr_pkg::ST_OK;
				return;
			end
			if (m_epochs >= cap) begin
				st = bgdr_pkg::ST_CAP;
				return;
			end
			for (int j = 0; j < 3; j++)
				m_w[j] = sat_add(m_w[j], sat_mul(g[j], {16'b0, m_rate}, 24));
		end
	endtask

	task automatic apply_req(input req_t q, output fit_t f);
		f.status = bgdr_pkg::ST_OK;
		f.pred = '0;
		case (q.act)
			bgdr_pkg::ACT_LOAD: begin
				if (s_cnt >= STORE_SIZE) begin
					f.status = bgdr_pkg::ST_FULL;
				end else begin
					s_fa[s_cnt] = q.fa;
					s_fb[s_cnt] = q.fb;
					s_tgt[s_cnt] = q.tgt;
					s_cnt++;
				end
			end
			bgdr_pkg::ACT_TRAIN: fit_model(f.status);
			bgdr_pkg::ACT_PREDICT: f.pred = model_out(q.fa, q.fb);
			default: s_cnt = 0;
		endcase
		f.w0 = m_w[0];
		f.w1 = m_w[1];
		f.w2 = m_w[2];
		f.cost = m_cost[47:0];
		f.epochs = m_epochs;
		f.total = 5'(s_cnt);
	endtask

	task automatic cmp(string nm, logic [63:0] e, logic [63:0] g);
		if (e !== g) begin
			$error("%s mismatch: expected %h, got %h", nm, e, g);
			n_fail++;
		end
	endtask

	// Input driver: one transfer per queued request, random gaps between
	always @(negedge clk) begin
		req_t q;
		if (arst_n && !(in_valid && !in_took)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				q = pending_q.pop_front();
				action <= q.act;
				feature_a <= q.fa;
				feature_b <= q.fb;
				target <= q.tgt;
				in_valid <= 1'b1;
				in_gap = quiet ? 0 : $urandom_range(0, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stall per result, plus a long hold on request
	always @(negedge clk) begin
		if (pressure_req) begin
			pressure_req = 0;
			hold_left = 400;
		end
		if (out_took) out_gap = quiet ? 0 : $urandom_range(0, 7);
		else if (out_gap > 0) out_gap--;
		if (hold_left > 0) hold_left--;
		out_stall <= arst_n && (hold_left > 0 || out_gap > 0);
	end

	// Monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		req_t q;
		fit_t f, e;
		in_took = in_valid && !in_stall;
		out_took = out_valid && !out_stall;
		if (arst_n && in_took) begin
			q = '{action, feature_a, feature_b, target};
			apply_req(q, f);
			fit_q.push_back(f);
			case (f.status)
				bgdr_pkg::ST_FULL: n_full++;
				bgdr_pkg::ST_EMPTY: n_empty++;
				bgdr_pkg::ST_CAP: n_cap++;
				default: if (q.act == bgdr_pkg::ACT_TRAIN) n_conv++;
			endcase
			if (q.act == bgdr_pkg::ACT_TRAIN) n_epochs += f.epochs;
			if (q.act == bgdr_pkg::ACT_PREDICT) n_pred++;
		end
		if (arst_n && out_took) begin
			if (fit_q.size() == 0) begin
				$error("result with no request outstanding");
				n_fail++;
			end else begin
				e = fit_q.pop_front();
				cmp("status", e.status, status);
				cmp("weight_bias", e.w0, weight_bias);
				cmp("weight_a", e.w1, weight_a);
				cmp("weight_b", e.w2, weight_b);
				cmp("cost", e.cost, cost);
				cmp("epochs_run", e.epochs, epochs_run);
				cmp("prediction", e.pred, prediction);
				cmp("sample_total", e.total, sample_total);
			end
			n_checked++;
		end
		// watchdog on cycles without any transfer
		if (in_took || out_took || (cfg_valid && cfg_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic add(logic [1:0] act, logic [15:0] a, logic [15:0] b,
		logic signed [31:0] t);
		pending_q.push_back('{act, a, b, t});
		n_sent++;
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			bgdr_pkg::REG_RATE: m_rate = d[47:0];
			bgdr_pkg::REG_LIMIT: m_limit = d[47:0];
			bgdr_pkg::REG_BIAS: m_init[0] = d;
			bgdr_pkg::REG_WA: m_init[1] = d;
			bgdr_pkg::REG_WB: m_init[2] = d;
			bgdr_pkg::REG_EPOCHS: m_cap = d[19:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		wait (n_checked == n_sent && pending_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_feat();
		return ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
	endfunction

	function automatic logic signed [31:0] rand_tgt();
		return ($urandom_range(0, 2) == 0) ? 32'($urandom) : $signed($urandom_range(0, 1 << 24))
			- (1 << 23);
	endfunction

	function automatic logic [63:0] rand_weight();
		if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
		return 64'($signed($urandom_range(0, 1 << 30)) - (1 << 29)) <<< 14;
	endfunction

	initial begin
		logic [1:0] act;
		int         n_load;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset model, empty store, extremes of every field
		add(bgdr_pkg::ACT_PREDICT, 16'hFFFF, 16'h0000, '0);
		add(bgdr_pkg::ACT_PREDICT, 16'h0000, 16'hFFFF, '0);
		add(bgdr_pkg::ACT_TRAIN, '0, '0, '0);
		wait_idle();
		cfg_write(bgdr_pkg::REG_EPOCHS, 20'd3);
		cfg_write(bgdr_pkg::REG_LIMIT, '0);
		add(bgdr_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF);
		add(bgdr_pkg::ACT_LOAD, 16'h0000, 16'h0000, 32'sh80000000);
		add(bgdr_pkg::ACT_LOAD, 16'd5, 16'd9, 32'sh00030000);
		add(bgdr_pkg::ACT_TRAIN, '0, '0, '0);
		add(bgdr_pkg::ACT_PREDICT, 16'hFFFF, 16'hFFFF, '0);
		for (int i = 0; i < 14; i++)
			add(bgdr_pkg::ACT_LOAD, rand_feat(), rand_feat(), rand_tgt());
		add(bgdr_pkg::ACT_TRAIN, '0, '0, '0);
		add(bgdr_pkg::ACT_CLEAR, '0, '0, '0);
		add(bgdr_pkg::ACT_PREDICT, 16'd1, 16'd1, '0);
		wait_idle();
		// Register extremes: cap of zero, all-ones rate, saturated weights
		cfg_write(bgdr_pkg::REG_EPOCHS, '0);
		cfg_write(bgdr_pkg::REG_RATE, 48'hFFFF_FFFF_FFFF);
		cfg_write(bgdr_pkg::REG_BIAS, S64_MAX);
		cfg_write(bgdr_pkg::REG_WA, S64_MIN);
		cfg_write(bgdr_pkg::REG_WB, S64_MAX);
		cfg_write(3'd6, '1);
		cfg_write(3'd7, '1);
		add(bgdr_pkg::ACT_LOAD, 16'hFFFF, 16'h0001, 32'sh12345678);
		add(bgdr_pkg::ACT_TRAIN, '0, '0, '0);
		add(bgdr_pkg::ACT_PREDICT, 16'hFFFF, 16'hFFFF, '0);
		wait_idle();
		cfg_write(bgdr_pkg::REG_LIMIT, 48'hFFFF_FFFF_FFFF);
		cfg_write(bgdr_pkg::REG_EPOCHS, 20'hFFFFF);
		cfg_write(bgdr_pkg::REG_BIAS, S64_MIN);
		cfg_write(bgdr_pkg::REG_WA, S64_MAX);
		cfg_write(bgdr_pkg::REG_WB, S64_MIN);
		add(bgdr_pkg::ACT_TRAIN, '0, '0, '0);
		add(bgdr_pkg::ACT_PREDICT, 16'd0, 16'd0, '0);
		wait_idle();

		// Random phases: clear (most of the time), a batch of loads, train, then mostly predicts
		while (n_sent < N_ITEMS) begin
			cfg_write(bgdr_pkg::REG_RATE, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, 1 << 20)));
			cfg_write(bgdr_pkg::REG_LIMIT, ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, 1 << 16)));
			cfg_write(bgdr_pkg::REG_BIAS, rand_weight());
			cfg_write(bgdr_pkg::REG_WA, rand_weight());
			cfg_write(bgdr_pkg::REG_WB, rand_weight());
			cfg_write(bgdr_pkg::REG_EPOCHS, 64'($urandom_range(0, 4)));
			quiet = ($urandom_range(0, 4) == 0);
			// early phases always include a long receiver hold
			if (n_sent < 100 || $urandom_range(0, 9) == 0) begin
				@(posedge clk);
				pressure_req = 1;
			end
			if ($urandom_range(0, 3) != 0)
				add(bgdr_pkg::ACT_CLEAR, rand_feat(), rand_feat(), rand_tgt());
			n_load = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 10);
			for (int i = 0; i < n_load; i++)
				add(bgdr_pkg::ACT_LOAD, rand_feat(), rand_feat(), rand_tgt());
			add(bgdr_pkg::ACT_TRAIN, rand_feat(), rand_feat(), rand_tgt());
			for (int i = $urandom_range(2, 8); i > 0; i--) begin
				act = ($urandom_range(0, 5) == 0) ? 2'($urandom) : bgdr_pkg::ACT_PREDICT;
				if (act == bgdr_pkg::ACT_TRAIN && $urandom_range(0, 1) == 0)
					act = bgdr_pkg::ACT_PREDICT;
				add(act, rand_feat(), rand_feat(), rand_tgt());
			end
			wait_idle();
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (fit_q.size() != 0) begin
			$error("%0d results never arrived", fit_q.size());
			n_fail++;
		end
		$display("Covered %0d requests: %0d predicts, %0d loads refused as full,", n_sent,
			n_pred, n_full);
		$display("%0d fits converged, %0d hit the epoch cap, %0d on an empty store, %0d epochs",
			n_conv, n_cap, n_empty, n_epochs);
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
